// ----- rtl/core/pbcd_pkg.sv -----
// shared types, codes and the double-dabble step function for the packed bcd converter
// no dependencies; imported by pbcd_encode_pipe and packed_bcd_binary_converter
package pbcd_pkg;

    // largest packed word supported by the byte count input
    localparam int MAX_BYTES   = 4;
    localparam int WORD_BYTES  = 4;
    localparam int BYTE_LIMIT  = (MAX_BYTES > WORD_BYTES) ? WORD_BYTES :
                                 ((MAX_BYTES < 1) ? 1 : MAX_BYTES);

    // binary to bcd conversion: 8 digits kept, 32 input bits
    localparam int BCD_DIGITS    = 8;
    localparam int BIN_WIDTH     = 32;
    localparam int DABBLE_STEPS  = 8;
    localparam int DABBLE_STAGES = BIN_WIDTH / DABBLE_STEPS;

    localparam int VALUE_WIDTH = 27;
    localparam int PAIR_WIDTH  = 7;
    localparam int HALF_WIDTH  = 14;

    typedef enum logic [1:0] {
        CMD_DEC_BCD  = 2'd0,
        CMD_ENC_BCD  = 2'd1,
        CMD_DEC_TONE = 2'd2,
        CMD_ENC_TONE = 2'd3
    } cmd_t;

    // per-transaction control that travels down the pipeline
    typedef struct packed {
        cmd_t       cmd;
        logic       rev;
        logic [2:0] count;
        logic       inv;
        logic [1:0] tone;
    } ctrl_t;

    // partial state of a shift-and-add-3 conversion
    typedef struct packed {
        logic [4*BCD_DIGITS-1:0] bcd;
        logic [BIN_WIDTH-1:0]    bin;
    } dabble_t;

    // several double-dabble steps; carries out of the top digit are dropped,
    // which keeps the value modulo 10^8
    function automatic dabble_t dabble_steps(input dabble_t cur);
        dabble_t    r;
        logic [3:0] d;
        r = cur;
        for (int s = 0; s < DABBLE_STEPS; s++)
        begin
            for (int k = 0; k < BCD_DIGITS; k++)
            begin
                d = r.bcd[4*k +: 4];
                if (d >= 4'd5)
                begin
                    r.bcd[4*k +: 4] = d + 4'd3;
                end
            end
            r.bcd = {r.bcd[4*BCD_DIGITS-2:0], r.bin[BIN_WIDTH-1]};
            r.bin = {r.bin[BIN_WIDTH-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/pbcd_encode_pipe.sv -----
// pipelined binary to packed bcd conversion, a few double-dabble steps per stage
// depends on pbcd_pkg (dabble_t, dabble_steps, stage counts)
module pbcd_encode_pipe (
    input  logic        clk,
    input  logic [31:0] value,
    output logic [31:0] bcd
);
    import pbcd_pkg::*;

    dabble_t stage_in;
    dabble_t stage_reg [DABBLE_STAGES];

    // conversion starts with empty digits
    always_comb
    begin
        stage_in.bcd = '0;
        stage_in.bin = value;
    end

    // shift-and-add-3 stages
    always_ff @(posedge clk)
    begin
        stage_reg[0] <= dabble_steps(stage_in);
        for (int k = 1; k < DABBLE_STAGES; k++)
        begin
            stage_reg[k] <= dabble_steps(stage_reg[k-1]);
        end
    end

    assign bcd = stage_reg[DABBLE_STAGES-1].bcd;

endmodule

// ----- rtl/core/packed_bcd_binary_converter.sv -----
// top level of the packed bcd / binary converter: decode pipeline, encode pipe, result formatting
// depends on pbcd_pkg and pbcd_encode_pipe
//
// usage:
//   a transaction is taken at a clock edge where start is high and busy is low.
//   busy is always low: a new transaction may be started in every cycle.
//   command selects bcd decode, bcd encode, tone word decode or tone word encode.
//   the result appears on value_out, invalid_out and packed_out for exactly one
//   cycle with done high; the receiver cannot stall, so nothing waits inside.
// pipeline and throughput:
//   a transaction passes four pipeline stages (s1 to s4) and then the output register
//   before its result is on the ports.
//   one transaction per cycle; the depth is set by the 32 double-dabble steps of
//   encode, eight per stage, with the decode multiply-add tree alongside.
// reset:
//   rst_n clears the valid bits of every stage and the done strobe; transactions
//   in flight are dropped.
module packed_bcd_binary_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic        high_pair_first,
    input  logic [2:0]  byte_count,
    input  logic [31:0] packed_in,
    input  logic [31:0] value_in,
    input  logic        invalid_in,
    output logic        done,
    output logic [26:0] value_out,
    output logic        invalid_out,
    output logic [31:0] packed_out
);
    import pbcd_pkg::*;

    logic       accept;
    cmd_t       cmd_in;
    logic [2:0] count_in;
    ctrl_t      in_ctrl;
    logic [31:0] dec_word;
    logic [31:0] enc_value;
    logic [31:0] enc_bcd;

    logic [PAIR_WIDTH-1:0] s1_pair_next [WORD_BYTES];
    logic                  s1_bad_next;

    logic                  s1_valid_reg;
    ctrl_t                 s1_ctrl_reg;
    logic [PAIR_WIDTH-1:0] s1_pair_reg [WORD_BYTES];
    logic                  s1_bad_reg;

    logic                  s2_valid_reg;
    ctrl_t                 s2_ctrl_reg;
    logic [HALF_WIDTH-1:0] s2_half_reg [2];
    logic                  s2_bad_reg;

    logic                   s3_valid_reg;
    ctrl_t                  s3_ctrl_reg;
    logic [VALUE_WIDTH-1:0] s3_value_reg;
    logic                   s3_bad_reg;

    logic                   s4_valid_reg;
    ctrl_t                  s4_ctrl_reg;
    logic [VALUE_WIDTH-1:0] s4_value_reg;
    logic                   s4_bad_reg;

    logic                   done_reg;
    logic [VALUE_WIDTH-1:0] value_out_reg;
    logic                   invalid_out_reg;
    logic [31:0]            packed_out_reg;
    logic [VALUE_WIDTH-1:0] value_out_next;
    logic                   invalid_out_next;
    logic [31:0]            packed_out_next;

    // handshake: the pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // byte count clamp
    always_comb
    begin
        priority if (byte_count == 3'd0)
        begin
            count_in = 3'd1;
        end
        else if (byte_count > 3'(BYTE_LIMIT))
        begin
            count_in = 3'(BYTE_LIMIT);
        end
        else
        begin
            count_in = byte_count;
        end
    end

    // control for the transaction; tone words are two bytes, low pair first
    assign cmd_in = cmd_t'(command);

    always_comb
    begin
        in_ctrl.cmd   = cmd_in;
        in_ctrl.inv   = invalid_in;
        in_ctrl.rev   = high_pair_first;
        in_ctrl.count = count_in;
        in_ctrl.tone  = value_in[17:16];
        dec_word      = packed_in;
        enc_value     = value_in;
        unique case (cmd_in)
            CMD_DEC_BCD, CMD_ENC_BCD:
            begin
            end
            CMD_DEC_TONE:
            begin
                in_ctrl.rev   = 1'b0;
                in_ctrl.count = 3'd2;
                in_ctrl.tone  = packed_in[15:14];
                dec_word      = {18'd0, packed_in[13:0]};
            end
            CMD_ENC_TONE:
            begin
                in_ctrl.rev   = 1'b0;
                in_ctrl.count = 3'd2;
                enc_value     = {16'd0, value_in[15:0]};
            end
            default:
            begin
            end
        endcase
    end

    // decode front: pick the byte for each digit pair, check nibbles, pair value
    always_comb
    begin
        logic [2:0] pos;
        logic [7:0] byte_val;
        logic       used;
        s1_bad_next = 1'b0;
        for (int j = 0; j < WORD_BYTES; j++)
        begin
            pos      = in_ctrl.rev ? (in_ctrl.count - 3'd1 - 3'(j)) : 3'(j);
            used     = (3'(j) < in_ctrl.count);
            byte_val = used ? dec_word[{pos[1:0], 3'b000} +: 8] : 8'd0;
            if (byte_val[7:4] > 4'd9 || byte_val[3:0] > 4'd9)
            begin
                s1_bad_next = 1'b1;
            end
            s1_pair_next[j] = PAIR_WIDTH'(byte_val[7:4]) * PAIR_WIDTH'(10)
                            + PAIR_WIDTH'(byte_val[3:0]);
        end
    end

    // encode datapath
    pbcd_encode_pipe u_encode (
        .clk   (clk),
        .value (enc_value),
        .bcd   (enc_bcd)
    );

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= s4_valid_reg;
        end
    end

    // decode pipeline payload: pairs, then halves, then full value
    always_ff @(posedge clk)
    begin
        s1_ctrl_reg <= in_ctrl;
        s1_bad_reg  <= s1_bad_next;
        for (int j = 0; j < WORD_BYTES; j++)
        begin
            s1_pair_reg[j] <= s1_pair_next[j];
        end

        s2_ctrl_reg <= s1_ctrl_reg;
        s2_bad_reg  <= s1_bad_reg;
        for (int h = 0; h < 2; h++)
        begin
            s2_half_reg[h] <= HALF_WIDTH'(s1_pair_reg[2*h+1]) * HALF_WIDTH'(100)
                            + HALF_WIDTH'(s1_pair_reg[2*h]);
        end

        s3_ctrl_reg  <= s2_ctrl_reg;
        s3_bad_reg   <= s2_bad_reg;
        s3_value_reg <= VALUE_WIDTH'(s2_half_reg[1]) * VALUE_WIDTH'(10000)
                      + VALUE_WIDTH'(s2_half_reg[0]);

        s4_ctrl_reg  <= s3_ctrl_reg;
        s4_bad_reg   <= s3_bad_reg;
        s4_value_reg <= s3_value_reg;
    end

    // result formatting
    always_comb
    begin
        logic [2:0] pos;
        pos              = 3'd0;
        value_out_next   = '0;
        invalid_out_next = 1'b0;
        packed_out_next  = '0;
        unique case (s4_ctrl_reg.cmd)
            CMD_DEC_BCD:
            begin
                invalid_out_next = s4_bad_reg;
                value_out_next   = s4_bad_reg ? '0 : s4_value_reg;
            end
            CMD_DEC_TONE:
            begin
                invalid_out_next = s4_bad_reg;
                value_out_next   = s4_bad_reg ? '0 :
                                   (s4_value_reg | VALUE_WIDTH'({s4_ctrl_reg.tone, 16'd0}));
            end
            CMD_ENC_BCD:
            begin
                for (int j = 0; j < WORD_BYTES; j++)
                begin
                    pos = s4_ctrl_reg.rev ? (s4_ctrl_reg.count - 3'd1 - 3'(j)) : 3'(j);
                    if (3'(j) < s4_ctrl_reg.count)
                    begin
                        packed_out_next[{pos[1:0], 3'b000} +: 8] =
                            s4_ctrl_reg.inv ? 8'hFF : enc_bcd[8*j +: 8];
                    end
                end
            end
            CMD_ENC_TONE:
            begin
                packed_out_next = {16'd0, enc_bcd[15:0] | {s4_ctrl_reg.tone, 14'd0}};
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        value_out_reg   <= value_out_next;
        invalid_out_reg <= invalid_out_next;
        packed_out_reg  <= packed_out_next;
    end

    assign done        = done_reg;
    assign value_out   = value_out_reg;
    assign invalid_out = invalid_out_reg;
    assign packed_out  = packed_out_reg;

endmodule
